FILE: rtl/round_robin_download_picker_top_macros.svh
// assertion macros for the round robin download picker
`ifndef ROUND_ROBIN_DOWNLOAD_PICKER_TOP_MACROS_SVH
`define ROUND_ROBIN_DOWNLOAD_PICKER_TOP_MACROS_SVH

// consequent holds in the same cycle
`define RRDP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rrdp assertion failed");

// consequent holds in the next cycle
`define RRDP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rrdp assertion failed");

`endif

FILE: rtl/rrdp_pkg.sv
// shared constants, codes and control structs of the download picker
package rrdp_pkg;

  localparam int MaxChannels       = 8;
  localparam int EntriesPerChannel = 256;

  localparam int KindW  = 2;
  localparam int ChW    = 3;
  localparam int NumChW = 4;
  localparam int IdxW   = 8;
  localparam int CntW   = 9;
  localparam int TagW   = 32;
  localparam int FlagW  = 3;
  localparam int AddrW  = ChW + IdxW;
  localparam int MemDepth = MaxChannels * EntriesPerChannel;

  typedef enum logic [KindW-1:0] {
    KIND_PICK  = 2'd0,
    KIND_FLAGS = 2'd1,
    KIND_SETUP = 2'd2,
    KIND_WRITE = 2'd3
  } kind_e;

  typedef struct packed {
    logic latch;
    logic mod_step;
    logic chan_next;
    logic scan_init;
    logic scan_issue;
    logic pick_hit;
    logic pick_miss;
    logic flag_rd;
    logic flag_wr;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic c_ge_n;
    logic chan_ok;
    logic k_last;
    logic hit;
    logic exhausted;
  } sts_t;

endpackage

FILE: rtl/rrdp_ctrl.sv
// controller state machine of the download picker
`include "round_robin_download_picker_top_macros.svh"

module rrdp_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rrdp_pkg::KindW-1:0] kind_i,
  input  rrdp_pkg::sts_t            sts_i,
  output rrdp_pkg::cmd_t            cmd_o,
  output logic                      busy_o,
  output logic                      done_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PMOD,
    ST_PCHAN,
    ST_PSCAN,
    ST_FRD,
    ST_FWR,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    done_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          case (rrdp_pkg::kind_e'(kind_i))
            rrdp_pkg::KIND_PICK:  state_d = ST_PMOD;
            rrdp_pkg::KIND_FLAGS: state_d = ST_FRD;
            default:              state_d = ST_EXEC;
          endcase
        end
      end
      ST_PMOD: begin
        if (sts_i.n_zero) begin
          cmd_o.pick_miss = 1'b1;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else if (sts_i.c_ge_n) begin
          cmd_o.mod_step = 1'b1;
        end else begin
          state_d = ST_PCHAN;
        end
      end
      ST_PCHAN: begin
        if (sts_i.chan_ok) begin
          cmd_o.scan_init = 1'b1;
          state_d = ST_PSCAN;
        end else if (sts_i.k_last) begin
          cmd_o.pick_miss = 1'b1;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.chan_next = 1'b1;
        end
      end
      ST_PSCAN: begin
        if (sts_i.hit) begin
          cmd_o.pick_hit = 1'b1;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else if (sts_i.exhausted) begin
          if (sts_i.k_last) begin
            cmd_o.pick_miss = 1'b1;
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            cmd_o.chan_next = 1'b1;
            state_d = ST_PCHAN;
          end
        end else begin
          cmd_o.scan_issue = 1'b1;
        end
      end
      ST_FRD: begin
        cmd_o.flag_rd = 1'b1;
        state_d = ST_FWR;
      end
      ST_FWR: begin
        cmd_o.flag_wr = 1'b1;
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

  `RRDP_ASSERT_NEXT(a_busy_after_start, start_i && !busy_o, busy_o)
  `RRDP_ASSERT_SAME(a_done_when_idle, done_o, !busy_o)
  `RRDP_ASSERT_NEXT(a_done_single, done_o, !done_o)

endmodule

FILE: rtl/rrdp_dp.sv
// datapath of the download picker: channel registers, entry memory, scan counters
module rrdp_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rrdp_pkg::cmd_t                  cmd_i,
  output rrdp_pkg::sts_t                  sts_o,
  input  logic [rrdp_pkg::KindW-1:0]      kind_i,
  input  logic [rrdp_pkg::ChW-1:0]        channel_sel_i,
  input  logic [rrdp_pkg::IdxW-1:0]       entry_index_i,
  input  logic [rrdp_pkg::TagW-1:0]       entry_tag_i,
  input  logic [rrdp_pkg::FlagW-1:0]      flag_bits_i,
  input  logic                            channel_ready_i,
  input  logic [rrdp_pkg::CntW-1:0]       entry_count_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rrdp_pkg::NumChW-1:0]     cfg_data_i,
  output logic                            found_o,
  output logic [rrdp_pkg::ChW-1:0]        picked_channel_o,
  output logic [rrdp_pkg::IdxW-1:0]       picked_index_o,
  output logic [rrdp_pkg::TagW-1:0]       picked_tag_o,
  output logic                            applied_o
);

  localparam int ChW   = rrdp_pkg::ChW;
  localparam int IdxW  = rrdp_pkg::IdxW;
  localparam int CntW  = rrdp_pkg::CntW;
  localparam int NChW  = rrdp_pkg::NumChW;
  localparam int TagW  = rrdp_pkg::TagW;
  localparam int FlagW = rrdp_pkg::FlagW;
  localparam int NCh   = rrdp_pkg::MaxChannels;

  // channel state
  logic [NChW-1:0] numch_q;
  logic [ChW-1:0]  ptr_q;
  logic [IdxW-1:0] cursor_q [NCh];
  logic [CntW-1:0] count_q  [NCh];
  logic [NCh-1:0]  rdy_q;

  // latched request
  logic [rrdp_pkg::KindW-1:0] kind_q;
  logic [ChW-1:0]  ch_q;
  logic [IdxW-1:0] idx_q;
  logic [TagW-1:0] tag_q;
  logic [FlagW-1:0] fl_q;
  logic            rdy_in_q;
  logic [CntW-1:0] cnt_in_q;

  // scan state
  logic [ChW-1:0]  c_q;
  logic [ChW-1:0]  k_q;
  logic [IdxW-1:0] i_q;
  logic [IdxW-1:0] ip_q;
  logic [CntW-1:0] t_q;
  logic            pend_q;

  // entry memory
  logic [FlagW-1:0] flag_mem [rrdp_pkg::MemDepth];
  logic [TagW-1:0]  tag_mem  [rrdp_pkg::MemDepth];
  logic [FlagW-1:0] rflags_q;
  logic [TagW-1:0]  rtag_q;

  logic [NChW-1:0]  n;
  logic [ChW-1:0]   c_next;
  logic [CntW-1:0]  cnt_cur;
  logic [IdxW-1:0]  i_next;
  logic [IdxW-1:0]  ip_next;
  logic [CntW-1:0]  cnt_clamp;
  logic             apply;
  logic             is_write;
  logic             is_setup;
  logic [rrdp_pkg::AddrW-1:0] addr;
  logic             rd_en;
  logic             flag_we;
  logic [FlagW-1:0] flag_wdata;

  assign cfg_ready_o = 1'b1;

  assign n = (numch_q > NChW'(NCh)) ? NChW'(NCh) : numch_q;
  assign c_next  = (({1'b0, c_q} + NChW'(1)) == n) ? '0 : c_q + ChW'(1);
  assign cnt_cur = count_q[c_q];
  assign i_next  = (({1'b0, i_q} + CntW'(1)) == cnt_cur) ? '0 : i_q + IdxW'(1);
  assign ip_next = (({1'b0, ip_q} + CntW'(1)) == cnt_cur) ? '0 : ip_q + IdxW'(1);
  assign cnt_clamp = (cnt_in_q > CntW'(rrdp_pkg::EntriesPerChannel)) ?
                     CntW'(rrdp_pkg::EntriesPerChannel) : cnt_in_q;
  assign apply = ({1'b0, idx_q} < count_q[ch_q]) && (rtag_q == tag_q);
  assign is_write = (kind_q == rrdp_pkg::KIND_WRITE);
  assign is_setup = (kind_q == rrdp_pkg::KIND_SETUP);

  assign sts_o.n_zero    = (n == '0);
  assign sts_o.c_ge_n    = ({1'b0, c_q} >= n);
  assign sts_o.chan_ok   = rdy_q[c_q] && (cnt_cur != '0);
  assign sts_o.k_last    = (k_q == ChW'(n - NChW'(1)));
  assign sts_o.hit       = pend_q && (rflags_q == '0);
  assign sts_o.exhausted = (t_q == cnt_cur);

  assign addr       = cmd_i.scan_issue ? {c_q, i_q} : {ch_q, idx_q};
  assign rd_en      = cmd_i.scan_issue || cmd_i.flag_rd;
  assign flag_we    = (cmd_i.flag_wr && apply) || (cmd_i.exec && is_write);
  assign flag_wdata = cmd_i.flag_wr ? (rflags_q | fl_q) : fl_q;

  always_ff @(posedge clk_i) begin
    if (flag_we) begin
      flag_mem[addr] <= flag_wdata;
    end
    if (cmd_i.exec && is_write) begin
      tag_mem[addr] <= tag_q;
    end
    if (rd_en) begin
      rflags_q <= flag_mem[addr];
      rtag_q   <= tag_mem[addr];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      numch_q <= '0;
      ptr_q   <= '0;
      rdy_q   <= '0;
      pend_q  <= 1'b0;
      for (int j = 0; j < NCh; j++) begin
        cursor_q[j] <= '0;
        count_q[j]  <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        numch_q <= cfg_data_i;
      end
      if (cmd_i.scan_init) begin
        pend_q <= 1'b0;
      end else if (cmd_i.scan_issue) begin
        pend_q <= 1'b1;
      end
      if (cmd_i.pick_hit) begin
        cursor_q[c_q] <= ip_next;
        ptr_q         <= c_next;
      end
      if (cmd_i.exec && is_setup) begin
        rdy_q[ch_q]   <= rdy_in_q;
        count_q[ch_q] <= cnt_clamp;
        if ({1'b0, cursor_q[ch_q]} >= cnt_clamp) begin
          cursor_q[ch_q] <= '0;
        end
      end
    end
  end

  // request, scan and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q   <= kind_i;
      ch_q     <= channel_sel_i;
      idx_q    <= entry_index_i;
      tag_q    <= entry_tag_i;
      fl_q     <= flag_bits_i;
      rdy_in_q <= channel_ready_i;
      cnt_in_q <= entry_count_i;
      c_q      <= ptr_q;
      k_q      <= '0;
    end
    if (cmd_i.mod_step) begin
      c_q <= ChW'({1'b0, c_q} - n);
    end
    if (cmd_i.chan_next) begin
      c_q <= c_next;
      k_q <= k_q + ChW'(1);
    end
    if (cmd_i.scan_init) begin
      i_q <= cursor_q[c_q];
      t_q <= '0;
    end
    if (cmd_i.scan_issue) begin
      ip_q <= i_q;
      i_q  <= i_next;
      t_q  <= t_q + CntW'(1);
    end
    if (cmd_i.pick_hit) begin
      found_o          <= 1'b1;
      picked_channel_o <= c_q;
      picked_index_o   <= ip_q;
      picked_tag_o     <= rtag_q;
      applied_o        <= 1'b0;
    end
    if (cmd_i.pick_miss || cmd_i.exec || cmd_i.flag_wr) begin
      found_o          <= 1'b0;
      picked_channel_o <= '0;
      picked_index_o   <= '0;
      picked_tag_o     <= '0;
      applied_o        <= cmd_i.flag_wr && apply;
    end
  end

endmodule

FILE: rtl/round_robin_download_picker_top.sv
// top level of the round robin download picker
// usage:
//   raise start_i with a request on the input ports; it is taken at an edge
//   where busy_o is low. each request gives one result on the result ports,
//   marked by done_o for exactly one cycle; the receiver cannot stall it.
//   num_channels is written over cfg_valid_i/cfg_ready_o/cfg_data_i while
//   the block is idle; cfg_ready_o is always high.
// sequence (accept to done_o):
//   write entry and set up channel: one exec state
//   set flags: one memory read, then read-modify-write
//   pick: the pointer is reduced modulo the channel count, then each visited
//   channel is checked and, if ready and not empty, its entries are scanned
//   from its cursor until an entry with all flags clear is found.
//   the entry scan reads one memory word per cycle from the single port.
// throughput: one request at a time; the next is taken in the done cycle.
// reset: pointer, cursors, counts and ready bits clear at once; the entry
//   memory is not cleared and must be written before it is read.
module round_robin_download_picker_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [rrdp_pkg::KindW-1:0]        kind_i,
  input  logic [rrdp_pkg::ChW-1:0]          channel_sel_i,
  input  logic [rrdp_pkg::IdxW-1:0]         entry_index_i,
  input  logic signed [rrdp_pkg::TagW-1:0]  entry_tag_i,
  input  logic [rrdp_pkg::FlagW-1:0]        flag_bits_i,
  input  logic                              channel_ready_i,
  input  logic [rrdp_pkg::CntW-1:0]         entry_count_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rrdp_pkg::NumChW-1:0]       cfg_data_i,
  output logic                              done_o,
  output logic                              found_o,
  output logic [rrdp_pkg::ChW-1:0]          picked_channel_o,
  output logic [rrdp_pkg::IdxW-1:0]         picked_index_o,
  output logic signed [rrdp_pkg::TagW-1:0]  picked_tag_o,
  output logic                              applied_o
);

  rrdp_pkg::cmd_t cmd;
  rrdp_pkg::sts_t sts;
  logic [rrdp_pkg::TagW-1:0] picked_tag;

  rrdp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .kind_i  (kind_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  rrdp_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .kind_i           (kind_i),
    .channel_sel_i    (channel_sel_i),
    .entry_index_i    (entry_index_i),
    .entry_tag_i      ($unsigned(entry_tag_i)),
    .flag_bits_i      (flag_bits_i),
    .channel_ready_i  (channel_ready_i),
    .entry_count_i    (entry_count_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .found_o          (found_o),
    .picked_channel_o (picked_channel_o),
    .picked_index_o   (picked_index_o),
    .picked_tag_o     (picked_tag),
    .applied_o        (applied_o)
  );

  assign picked_tag_o = $signed(picked_tag);

endmodule
